// ===== hdl/value_stack_with_match_delete_unit_defines.svh =====
// Assertion macros used by the value stack RTL.
`ifndef VALUE_STACK_WITH_MATCH_DELETE_UNIT_DEFINES_SVH
`define VALUE_STACK_WITH_MATCH_DELETE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VSMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VSMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vsmd_pkg.sv =====
// Types, constants and codes for the value stack with match delete.
package vsmd_pkg;

	// storage geometry
	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int HEAD_W = 32;
	localparam int LEN_W  = 5;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_COUNT  = 2'd2,
		OP_DELETE = 2'd3
	} op_e;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_e;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_HEAD,
		S_HWAIT
	} state_e;

	// input beat
	typedef struct packed {
		op_e         kind;
		logic [31:0] value;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic [31:0] head_value;
		logic [4:0]  list_length;
		logic        is_empty;
		logic [4:0]  match_count;
		status_e     status;
	} res_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic exec;
		logic scan;
		logic head_rd;
		logic finish;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_op;
		logic scan_done;
	} sts_t;

endpackage

// ===== hdl/vsmd_ctrl.sv =====
// Controller state machine sequencing each operation.
module vsmd_ctrl
	import vsmd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	state_e state_q;
	state_e state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = sts.scan_op ? S_SCAN : S_HEAD;
			end
			S_SCAN: begin
				if (sts.scan_done) state_nxt = S_HEAD;
			end
			S_HEAD: begin
				state_nxt = S_HWAIT;
			end
			S_HWAIT: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				ctl.accept = start;
			end
			S_EXEC:  ctl.exec    = 1'b1;
			S_SCAN:  ctl.scan    = 1'b1;
			S_HEAD:  ctl.head_rd = 1'b1;
			S_HWAIT: ctl.finish  = 1'b1;
			default: busy        = 1'b1;
		endcase
	end

endmodule

// ===== hdl/vsmd_dp.sv =====
// Datapath: entry memory, fill count, scan counters and result register.
module vsmd_dp
	import vsmd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  ctl_t ctl,
	output sts_t sts,
	output res_t result,
	output logic done
);

	// entry memory, oldest in slot 0
	logic [VALUE_W-1:0] mem_q [DEPTH];

	op_e                op_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   wr_q;
	logic [CNT_W-1:0]   match_q;
	status_e            status_q;
	logic               rd_vld_s1;
	logic [VALUE_W-1:0] rdata_s1;
	res_t               result_q;
	logic               done_q;

	logic               full;
	logic               empty;
	logic               match_s1;
	logic               keep_s1;
	logic               scan_done;
	logic               issue;
	logic [CNT_W-1:0]   wr_nxt;
	logic [CNT_W-1:0]   fill_m1;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [VALUE_W-1:0] wdata;
	logic               re;
	logic [IDX_W-1:0]   raddr;

	// scan compare and compaction
	always_comb begin
		full      = (fill_q == CNT_W'(DEPTH));
		empty     = (fill_q == '0);
		match_s1  = rd_vld_s1 && (rdata_s1 == value_q);
		keep_s1   = rd_vld_s1 && !match_s1;
		wr_nxt    = wr_q + CNT_W'(keep_s1);
		scan_done = (rd_idx_q == fill_q);
		issue     = ctl.scan && !scan_done;
		fill_m1   = fill_q - CNT_W'(1);
	end

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = fill_q[IDX_W-1:0];
		wdata = value_q;
		if (ctl.exec && (op_q == OP_PUSH) && !full) begin
			we = 1'b1;
		end else if (ctl.scan && (op_q == OP_DELETE) && keep_s1) begin
			we    = 1'b1;
			waddr = wr_q[IDX_W-1:0];
			wdata = rdata_s1;
		end
		re    = issue || ctl.head_rd;
		raddr = ctl.head_rd ? fill_m1[IDX_W-1:0] : rd_idx_q[IDX_W-1:0];
	end

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_s1 <= mem_q[raddr];
	end

	// read valid flag for scan data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.exec) begin
			if ((op_q == OP_PUSH) && !full) fill_q <= fill_q + CNT_W'(1);
			else if ((op_q == OP_POP) && !empty) fill_q <= fill_m1;
		end else if (ctl.scan && scan_done && (op_q == OP_DELETE)) begin
			fill_q <= wr_nxt;
		end
	end

	// operation registers and scan counters
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			op_q     <= cmd.kind;
			value_q  <= cmd.value[VALUE_W-1:0];
			status_q <= ST_OK;
		end
		if (ctl.exec) begin
			rd_idx_q <= '0;
			wr_q     <= '0;
			match_q  <= '0;
			if ((op_q == OP_PUSH) && full) status_q <= ST_FULL;
			if ((op_q == OP_POP) && empty) status_q <= ST_EMPTY;
		end
		if (ctl.scan) begin
			if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
			if (match_s1) match_q <= match_q + CNT_W'(1);
			wr_q <= wr_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			result_q.head_value  <= empty ? '0 : HEAD_W'(rdata_s1);
			result_q.list_length <= LEN_W'(fill_q);
			result_q.is_empty    <= empty;
			result_q.match_count <= LEN_W'(match_q);
			result_q.status      <= status_q;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
		end
	end

	assign sts.scan_op   = (op_q == OP_COUNT) || (op_q == OP_DELETE);
	assign sts.scan_done = scan_done;
	assign result        = result_q;
	assign done          = done_q;

endmodule

// ===== hdl/value_stack_with_match_delete_unit.sv =====
// Top level of the bounded value stack with match count and match delete.
//
//  channel  | handshake      | payload          | direction
//  ---------+----------------+------------------+----------
//  command  | start / busy   | cmd (cmd_t)      | in
//  result   | done strobe    | result (res_t)   | out
//
// A beat is taken at a rising edge with start high and busy low.
// Push and pop: done rises after the execute, head read and result steps.
// Count and delete: a scan over the stored entries runs between execute and head read;
// the scan reads one stored entry per cycle through the single memory read port.
// busy drops in the cycle done is shown, so the next beat may be taken there.
// Reset clears the fill count and control; the receiver cannot stall done.
`include "value_stack_with_match_delete_unit_defines.svh"

module value_stack_with_match_delete_unit
	import vsmd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	ctl_t ctl;
	sts_t sts;

	// sequencing
	vsmd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// storage and scan
	vsmd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

	// checks
	`VSMD_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "beat taken but not busy")
	`VSMD_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`VSMD_ASSERT_IMP(a_empty_flag, clk, arst_n, done, result.is_empty == (result.list_length == LEN_W'(0)), "empty flag disagrees with length")
	`VSMD_ASSERT_IMP(a_full_len, clk, arst_n, done && (result.status == ST_FULL), result.list_length == LEN_W'(DEPTH), "push refused on a list not full")

endmodule

// ===== verif/vsmd_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the value stack: shadows the list and compares every done beat.
module vsmd_result_checker
	import vsmd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic done,
	input  res_t result,
	output int   mismatch_count,
	output int   results_owed
);

	// shadow copy of the list, slot shadow_fill-1 is the head
	logic [VALUE_W-1:0] shadow_list [DEPTH];
	int unsigned        shadow_fill;
	res_t               owed_q [$];
	int                 err_tally;

	// apply one command to the shadow list and form the result it should give
	task automatic stack_apply(input cmd_t c, output res_t r);
		int unsigned hits;
		int unsigned keep;
		status_e     st;
		hits = 0;
		keep = 0;
		st   = ST_OK;
		case (c.kind)
			OP_PUSH: begin
				if (shadow_fill >= DEPTH) begin
					st = ST_FULL;
				end else begin
					shadow_list[IDX_W'(shadow_fill)] = c.value;
					shadow_fill++;
				end
			end
			OP_POP: begin
				if (shadow_fill == 0) st = ST_EMPTY;
				else shadow_fill--;
			end
			OP_COUNT: begin
				for (int unsigned i = 0; i < shadow_fill; i++)
					if (shadow_list[IDX_W'(i)] == c.value) hits++;
			end
			default: begin
				// compact survivors towards slot 0, order kept
				for (int unsigned i = 0; i < shadow_fill; i++) begin
					if (shadow_list[IDX_W'(i)] == c.value) begin
						hits++;
					end else begin
						shadow_list[IDX_W'(keep)] = shadow_list[IDX_W'(i)];
						keep++;
					end
				end
				shadow_fill = keep;
			end
		endcase
		r.head_value  = (shadow_fill == 0) ? '0 : shadow_list[IDX_W'(shadow_fill - 1)];
		r.list_length = shadow_fill[4:0];
		r.is_empty    = (shadow_fill == 0);
		r.match_count = hits[4:0];
		r.status      = st;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
			err_tally++;
		end
	endtask

	// sample both channels at the rising edge; retire before predicting
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t fresh;
		if (!arst_n) begin
			shadow_fill = 0;
			owed_q.delete();
			err_tally = 0;
			mismatch_count <= 0;
			results_owed   <= 0;
		end else begin
			if (done) begin
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none got %p",
						$time, result);
					err_tally++;
				end else begin
					want = owed_q.pop_front();
					check_field("head_value", want.head_value, result.head_value);
					check_field("list_length", 32'(want.list_length),
						32'(result.list_length));
					check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
					check_field("match_count", 32'(want.match_count),
						32'(result.match_count));
					check_field("status", 32'(want.status), 32'(result.status));
				end
			end
			if (start && !busy) begin
				stack_apply(cmd, fresh);
				owed_q.push_back(fresh);
			end
			mismatch_count <= err_tally;
			results_owed   <= owed_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the value stack: drives command beats and gives the verdict.
module testbench;
	import vsmd_pkg::*;

	localparam int RANDOM_BEATS = 950;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int DRAIN_CYCLES = 24;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;
	int   mismatch_count;
	int   results_owed;
	int   cycle_count;

	// random mix, re-drawn every few dozen beats
	int            push_pct;
	bit            quiet;
	logic [31:0]   value_pool [4];
	int            roll;
	op_e           pick_op;
	logic [31:0]   pick_val;

	value_stack_with_match_delete_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	vsmd_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.done           (done),
		.result         (result),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one command beat: optional gap, then hold start until busy is seen low
	task automatic issue(input op_e k, input logic [31:0] v);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start     <= 1'b1;
		cmd.kind  <= k;
		cmd.value <= v;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		quiet       = 1'b0;
		push_pct    = 50;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty-list corners, matches at both value extremes
		issue(OP_POP, 32'h0);
		issue(OP_COUNT, 32'h0);
		issue(OP_DELETE, 32'hFFFF_FFFF);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_PUSH, 32'h0);
		issue(OP_COUNT, 32'h0);
		issue(OP_DELETE, 32'hFFFF_FFFF);
		issue(OP_DELETE, 32'h0);
		// fill to the brim, refused push, then count and delete everything
		for (int i = 0; i < DEPTH; i++) issue(OP_PUSH, 32'h5A5A_A5A5);
		issue(OP_PUSH, 32'h1234_5678);
		issue(OP_COUNT, 32'h5A5A_A5A5);
		issue(OP_DELETE, 32'h5A5A_A5A5);

		// random: small value pool so counts and deletes hit often
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       push_pct = 30;
					1:       push_pct = 55;
					default: push_pct = 80;
				endcase
				quiet = ($urandom_range(0, 3) == 0);
				foreach (value_pool[i]) value_pool[i] = $urandom;
				if ($urandom_range(0, 3) == 0) begin
					value_pool[0] = 32'h0;
					value_pool[1] = 32'hFFFF_FFFF;
				end
			end
			roll = $urandom_range(0, 99);
			if (roll < push_pct) begin
				pick_op = OP_PUSH;
			end else begin
				case (roll % 3)
					0:       pick_op = OP_POP;
					1:       pick_op = OP_COUNT;
					default: pick_op = OP_DELETE;
				endcase
			end
			pick_val = ($urandom_range(0, 3) == 0) ? $urandom
				: value_pool[2'($urandom_range(0, 3))];
			issue(pick_op, pick_val);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain
		while (results_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
